// ----- src/assert_macros.svh -----
// Assertion shorthands shared by the spectrum-to-XYZ RTL.
// Every macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/stxyz_pkg.sv -----
// Shared types, widths and colour-matching tables for the spectrum-to-XYZ block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stxyz_pkg;

  // Fixed field and state widths
  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 7;
  localparam int IDX_W     = 7;
  localparam int SCALE_W   = 24;
  localparam int OUT_W     = 32;
  localparam int SUM_W     = 38;
  localparam int COEF_W    = 15;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = SCALE_W;

  // Output scaling: sum (Q24.14) times scale (Q8.16), drop 30 fraction bits
  localparam int SUM_LO_W   = 32;
  localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
  localparam int LO_PROD_W  = SUM_LO_W + SCALE_W;
  localparam int HI_PROD_W  = SUM_HI_W + SCALE_W;
  localparam int TOT_W      = SUM_W + SCALE_W + 1;
  localparam int FRAC_SHIFT = 30;

  // Defaults for top-level parameters
  localparam int DEF_TABLE_SAMPLES = 81;
  localparam int DEF_SAMPLE_BITS   = 16;
  localparam int DEF_QUEUE_DEPTH   = 4;
  localparam int ROM_DEPTH         = 81;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = COUNT_W'(81);
  localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST = SCALE_W'(65536);

  typedef struct packed {
    logic              last;
    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
    logic [PROD_W-1:0] pz;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // CIE 1931 2-degree colour-matching functions, 380..780 nm, 5 nm, Q1.14
  localparam logic [COEF_W-1:0] CMF_X [0:ROM_DEPTH-1] = '{
    15'd23, 15'd36, 15'd69, 15'd126, 15'd234, 15'd380, 15'd713, 15'd1271,
    15'd2202, 15'd3519, 15'd4651, 15'd5382, 15'd5707, 15'd5703, 15'd5508,
    15'd5222, 15'd4764, 15'd4114, 15'd3201, 15'd2328, 15'd1566, 15'd950,
    15'd524, 15'd241, 15'd80, 15'd39, 15'd152, 15'd477, 15'd1037, 15'd1796,
    15'd2712, 15'd3698, 15'd4758, 15'd5893, 15'd7101, 15'd8390, 15'd9740,
    15'd11115, 15'd12486, 15'd13804, 15'd15013, 15'd16033, 15'd16815,
    15'd17313, 15'd17403, 15'd17131, 15'd16427, 15'd15375, 15'd13998,
    15'd12311, 15'd10525, 15'd8878, 15'd7338, 15'd5911, 15'd4645, 15'd3583,
    15'd2702, 15'd1986, 15'd1432, 15'd1042, 15'd767, 15'd539, 15'd372,
    15'd259, 15'd187, 15'd133, 15'd95, 15'd67, 15'd48, 15'd33, 15'd23,
    15'd16, 15'd11, 15'd8, 15'd5, 15'd3, 15'd3, 15'd2, 15'd2, 15'd2, 15'd0
  };

  localparam logic [COEF_W-1:0] CMF_Y [0:ROM_DEPTH-1] = '{
    15'd0, 15'd2, 15'd2, 15'd3, 15'd7, 15'd10, 15'd20, 15'd36, 15'd66,
    15'd120, 15'd190, 15'd275, 15'd377, 15'd488, 15'd623, 15'd786, 15'd983,
    15'd1211, 15'd1491, 15'd1845, 15'd2277, 15'd2774, 15'd3408, 15'd4237,
    15'd5292, 15'd6673, 15'd8241, 15'd9965, 15'd11633, 15'd12996, 15'd14123,
    15'd14990, 15'd15630, 15'd16061, 15'd16302, 15'd16384, 15'd16302,
    15'd16033, 15'd15598, 15'd14998, 15'd14254, 15'd13374, 15'd12403,
    15'd11385, 15'd10338, 15'd9286, 15'd8241, 15'd7229, 15'd6242, 15'd5259,
    15'd4342, 15'd3555, 15'd2867, 15'd2264, 15'd1753, 15'd1337, 15'd999,
    15'd731, 15'd524, 15'd380, 15'd279, 15'd195, 15'd134, 15'd93, 15'd67,
    15'd48, 15'd34, 15'd25, 15'd16, 15'd11, 15'd8, 15'd7, 15'd3, 15'd3,
    15'd2, 15'd2, 15'd2, 15'd0, 15'd0, 15'd0, 15'd0
  };

  // Z response is zero from 630 nm upward
  localparam logic [COEF_W-1:0] CMF_Z [0:ROM_DEPTH-1] = '{
    15'd106, 15'd172, 15'd329, 15'd593, 15'd1112, 15'd1806, 15'd3398,
    15'd6083, 15'd10578, 15'd17025, 15'd22702, 15'd26591, 15'd28624,
    15'd29206, 15'd29034, 15'd28575, 15'd27348, 15'd25036, 15'd21096,
    15'd17070, 15'd13320, 15'd10096, 15'd7622, 15'd5788, 15'd4456, 15'd3478,
    15'd2592, 15'd1830, 15'd1281, 15'd939, 15'd691, 15'd488, 15'd333,
    15'd220, 15'd143, 15'd93, 15'd64, 15'd44, 15'd34, 15'd29, 15'd28,
    15'd23, 15'd18, 15'd16, 15'd13, 15'd10, 15'd5, 15'd3, 15'd3, 15'd2,
    15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
    15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
    15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
    15'd0
  };

endpackage

// ----- src/spectrum_to_xyz_integrator_core.sv -----
// Top level of the CIE 1931 2-degree spectrum-to-XYZ integrator.
// Depends on stxyz_pkg, stxyz_front, stxyz_queue and stxyz_back.
//
//  Port group | Direction | Handshake          | Payload
//  -----------+-----------+--------------------+------------------------------------
//  cfg_       | in        | cfg_we             | cfg_index, cfg_wdata
//  in_        | in        | in_valid/in_stall  | in_sample
//  out_       | out       | out_valid/out_stall| out_x_value, out_y_value, out_z_value
//
// Rate: one sample per cycle within a spectrum while in_stall is low. Closing a
//   spectrum starts the back half's scaling (one split 38x24 multiply and one
//   round/saturate add per axis); the queue soaks up samples meanwhile.
// Path: front product register, queue, fin_*, then MUL and ADD per axis; out_valid
//   rises with the Z result.
// Reset: synchronous, active low; no clearing pass is needed.
// Stalls: in_stall rises only when the product stage and the queue are both
//   full; a stalled result blocks the next spectrum's scaling, not its intake.
`timescale 1ns / 1ps

module spectrum_to_xyz_integrator_core #(
  parameter int TABLE_SAMPLES = stxyz_pkg::DEF_TABLE_SAMPLES,
  parameter int SAMPLE_BITS   = stxyz_pkg::DEF_SAMPLE_BITS,
  parameter int QUEUE_DEPTH   = stxyz_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [stxyz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stxyz_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  // spectral samples
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [stxyz_pkg::SAMPLE_W-1:0]    in_sample,
  // XYZ results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [stxyz_pkg::OUT_W-1:0]       out_x_value,
  output logic [stxyz_pkg::OUT_W-1:0]       out_y_value,
  output logic [stxyz_pkg::OUT_W-1:0]       out_z_value
);
  import stxyz_pkg::*;

  logic [COUNT_W-1:0] sample_count_r, sample_count_nxt;
  logic [SCALE_W-1:0] scale_factor_r, scale_factor_nxt;

  q_entry_t q_wdata;
  q_entry_t q_rdata;
  q_stat_t  q_stat;
  logic     q_push;
  logic     q_pop;

  // Configuration registers; writes to unknown indexes fall through.
  always_comb begin
    sample_count_nxt = sample_count_r;
    scale_factor_nxt = scale_factor_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SAMPLE_COUNT: sample_count_nxt = cfg_wdata[COUNT_W-1:0];
        REG_SCALE_FACTOR: scale_factor_nxt = cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= SAMPLE_COUNT_RST;
      scale_factor_r <= SCALE_FACTOR_RST;
    end else begin
      sample_count_r <= sample_count_nxt;
      scale_factor_r <= scale_factor_nxt;
    end
  end

  // Front: index tracking, coefficient lookup, three products per sample
  stxyz_front #(
    .TABLE_SAMPLES (TABLE_SAMPLES),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .sample_count (sample_count_r),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // Decoupling queue: products plus end-of-spectrum mark
  stxyz_queue #(
    .W     ($bits(q_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: accumulate, scale, saturate, present result
  stxyz_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .scale_factor (scale_factor_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_x_value  (out_x_value),
    .out_y_value  (out_y_value),
    .out_z_value  (out_z_value)
  );

endmodule

// ----- src/stxyz_queue.sv -----
// Small flop-based FIFO between the front and back halves of the integrator.
// Depends on stxyz_pkg (status struct) and assert_macros.svh.
`timescale 1ns / 1ps

module stxyz_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic [W-1:0]       wdata,
  input  logic               pop,
  output logic [W-1:0]       rdata,
  output stxyz_pkg::q_stat_t stat
);
  import stxyz_pkg::*;
  `include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `STX_ASSERT_IMPL(a_q_no_overflow, push, !stat.full || pop, "queue push while full")
  `STX_ASSERT_IMPL(a_q_no_underflow, pop, !stat.empty, "queue pop while empty")

endmodule

// ----- src/stxyz_front.sv -----
// Front half: takes samples, tracks the wavelength index, looks up the
// colour-matching coefficients and forms the three products.
// Depends on stxyz_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module stxyz_front #(
  parameter int TABLE_SAMPLES = stxyz_pkg::DEF_TABLE_SAMPLES,
  parameter int SAMPLE_BITS   = stxyz_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [stxyz_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic [stxyz_pkg::COUNT_W-1:0]    sample_count,
  input  stxyz_pkg::q_stat_t               q_stat,
  output logic                             q_push,
  output stxyz_pkg::q_entry_t              q_wdata
);
  import stxyz_pkg::*;
  `include "assert_macros.svh"

  localparam int USE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << USE_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] TABLE_LIMIT = IDX_W'(TABLE_SAMPLES);

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              f_valid_r, f_valid_nxt;
  q_entry_t          f_entry_r, f_entry_nxt;
  logic              accept;
  logic              in_table;
  logic              last;
  logic [IDX_W:0]    idx_inc;
  logic [IDX_W:0]    count_eff;
  logic [COEF_W-1:0] cx, cy, cz;
  logic [PROD_W-1:0] smp;

  assign in_stall = f_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid_r && !q_stat.full;
  assign q_wdata  = f_entry_r;

  always_comb begin
    idx_inc   = {1'b0, idx_r} + (IDX_W + 1)'(1);
    // a count of zero behaves as one
    count_eff = (sample_count == '0) ? (IDX_W + 1)'(1) : {1'b0, sample_count};
    last      = (idx_inc >= count_eff);
    in_table  = (idx_r < TABLE_LIMIT);
    cx        = in_table ? CMF_X[idx_r] : '0;
    cy        = in_table ? CMF_Y[idx_r] : '0;
    cz        = in_table ? CMF_Z[idx_r] : '0;
    smp       = PROD_W'(in_sample & SAMPLE_MASK);

    idx_nxt     = idx_r;
    f_valid_nxt = f_valid_r;
    f_entry_nxt = f_entry_r;
    if (q_push) begin
      f_valid_nxt = 1'b0;
    end
    if (accept) begin
      f_valid_nxt      = 1'b1;
      f_entry_nxt.last = last;
      f_entry_nxt.px   = smp * PROD_W'(cx);
      f_entry_nxt.py   = smp * PROD_W'(cy);
      f_entry_nxt.pz   = smp * PROD_W'(cz);
      idx_nxt          = last ? '0 : idx_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      f_valid_r <= 1'b0;
    end else begin
      idx_r     <= idx_nxt;
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_entry_r <= f_entry_nxt;
  end

  `STX_ASSERT_NEXT(a_front_hold, f_valid_r && q_stat.full,
                   f_valid_r && $stable(f_entry_r), "front stage lost a held entry")

endmodule

// ----- src/stxyz_back.sv -----
// Back half: accumulates products, then scales the finished sums with a
// split 38x24 multiply and drives the result register.
// Depends on stxyz_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module stxyz_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  stxyz_pkg::q_stat_t             q_stat,
  input  stxyz_pkg::q_entry_t            q_rdata,
  output logic                           q_pop,
  input  logic [stxyz_pkg::SCALE_W-1:0]  scale_factor,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [stxyz_pkg::OUT_W-1:0]    out_x_value,
  output logic [stxyz_pkg::OUT_W-1:0]    out_y_value,
  output logic [stxyz_pkg::OUT_W-1:0]    out_z_value
);
  import stxyz_pkg::*;
  `include "assert_macros.svh"

  localparam int ACC_W = SUM_W + 1;

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_WAIT = 2'd1;
  localparam logic [1:0] SC_MUL  = 2'd2;
  localparam logic [1:0] SC_ADD  = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [TOT_W-1:0] ROUND_HALF = {{(TOT_W-1){1'b0}}, 1'b1} << (FRAC_SHIFT - 1);

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  a,
                                               input logic [PROD_W-1:0] b);
    logic [ACC_W-1:0] s;
    begin
      s = {1'b0, a} + ACC_W'(b);
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
    end
  endfunction

  logic [SUM_W-1:0]     sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt, sum_z_r, sum_z_nxt;
  logic [SUM_W-1:0]     fin_x_r, fin_x_nxt, fin_y_r, fin_y_nxt, fin_z_r, fin_z_nxt;
  logic [SUM_W-1:0]     add_x, add_y, add_z, sum_sel;
  logic [1:0]           sc_state_r, sc_state_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [LO_PROD_W-1:0] p_lo_r, p_lo_nxt;
  logic [HI_PROD_W-1:0] p_hi_r, p_hi_nxt;
  logic [TOT_W-1:0]     total;
  logic [OUT_W-1:0]     scaled;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_x_r, out_x_nxt, out_y_r, out_y_nxt, out_z_r, out_z_nxt;
  logic                 sc_busy;
  logic                 out_free;

  assign sc_busy  = (sc_state_r != SC_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  // the closing entry of a spectrum waits until the scaler has let go of fin_*
  assign q_pop    = !q_stat.empty && !(q_rdata.last && sc_busy);

  always_comb begin
    add_x = sat_add(sum_x_r, q_rdata.px);
    add_y = sat_add(sum_y_r, q_rdata.py);
    add_z = sat_add(sum_z_r, q_rdata.pz);

    case (axis_r)
      AXIS_X:  sum_sel = fin_x_r;
      AXIS_Y:  sum_sel = fin_y_r;
      default: sum_sel = fin_z_r;
    endcase

    total  = TOT_W'({p_hi_r, {SUM_LO_W{1'b0}}}) + TOT_W'(p_lo_r) + ROUND_HALF;
    scaled = (|total[TOT_W-1:FRAC_SHIFT+OUT_W]) ? '1
                                                : total[FRAC_SHIFT+OUT_W-1:FRAC_SHIFT];

    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    sum_z_nxt     = sum_z_r;
    fin_x_nxt     = fin_x_r;
    fin_y_nxt     = fin_y_r;
    fin_z_nxt     = fin_z_r;
    sc_state_nxt  = sc_state_r;
    axis_nxt      = axis_r;
    p_lo_nxt      = p_lo_r;
    p_hi_nxt      = p_hi_r;
    out_valid_nxt = out_valid_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (q_pop) begin
      if (q_rdata.last) begin
        fin_x_nxt    = add_x;
        fin_y_nxt    = add_y;
        fin_z_nxt    = add_z;
        sum_x_nxt    = '0;
        sum_y_nxt    = '0;
        sum_z_nxt    = '0;
        axis_nxt     = AXIS_X;
        sc_state_nxt = out_free ? SC_MUL : SC_WAIT;
      end else begin
        sum_x_nxt = add_x;
        sum_y_nxt = add_y;
        sum_z_nxt = add_z;
      end
    end

    case (sc_state_r)
      SC_IDLE: begin
      end
      SC_WAIT: begin
        if (out_free) begin
          sc_state_nxt = SC_MUL;
        end
      end
      SC_MUL: begin
        p_lo_nxt     = LO_PROD_W'(sum_sel[SUM_LO_W-1:0]) * LO_PROD_W'(scale_factor);
        p_hi_nxt     = HI_PROD_W'(sum_sel[SUM_W-1:SUM_LO_W]) * HI_PROD_W'(scale_factor);
        sc_state_nxt = SC_ADD;
      end
      SC_ADD: begin
        case (axis_r)
          AXIS_X:  out_x_nxt = scaled;
          AXIS_Y:  out_y_nxt = scaled;
          default: out_z_nxt = scaled;
        endcase
        if (axis_r == AXIS_Z) begin
          out_valid_nxt = 1'b1;
          sc_state_nxt  = SC_IDLE;
        end else begin
          axis_nxt     = axis_r + 2'd1;
          sc_state_nxt = SC_MUL;
        end
      end
      default: sc_state_nxt = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      sc_state_r  <= SC_IDLE;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      sum_z_r     <= sum_z_nxt;
      sc_state_r  <= sc_state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_x_r <= fin_x_nxt;
    fin_y_r <= fin_y_nxt;
    fin_z_r <= fin_z_nxt;
    p_lo_r  <= p_lo_nxt;
    p_hi_r  <= p_hi_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_x_value = out_x_r;
  assign out_y_value = out_y_r;
  assign out_z_value = out_z_r;

  `STX_ASSERT_IMPL(a_back_rise, $rose(out_valid_r),
                   $past(sc_state_r == SC_ADD && axis_r == AXIS_Z),
                   "result raised outside the last scaling step")
  `STX_ASSERT_IMPL(a_back_no_clobber, sc_state_r == SC_MUL || sc_state_r == SC_ADD,
                   !out_valid_r, "scaler running while a result is pending")

endmodule
